[sv/current_loop_duty_regulator_assert.svh]
// assertion macros for the current loop duty regulator
`ifndef CURRENT_LOOP_DUTY_REGULATOR_ASSERT_SVH
`define CURRENT_LOOP_DUTY_REGULATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define CLDR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("current loop regulator check failed");
`define CLDR_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("current loop regulator check failed");
`else
`define CLDR_ASSERT(lbl, prop)
`define CLDR_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[sv/cldr_pkg.sv]
// constants and types of the current loop duty regulator
package cldr_pkg;

    localparam int PWM_COUNTS     = 1024;
    localparam int GAIN_FULL      = 100;
    localparam int CURRENT_MIN_UA = 4000;
    localparam int CURRENT_MAX_UA = 20000;

    localparam int SPAN_UA  = CURRENT_MAX_UA - CURRENT_MIN_UA;
    localparam int DUTY_MAX = PWM_COUNTS - 1;
    localparam int STEP_DEN = CURRENT_MAX_UA * GAIN_FULL;

    // divider: remainder width and top quotient bit of the mapping pass
    localparam int DIV_W    = 37;
    localparam int MAP_TOP  = 14;

    // rounded step: floor((STEP_PRE * x + STEP_BIAS) / STEP_ODD), x = |err| * gain,
    // with the division done as a multiply by a reciprocal and a shift
    localparam int     STEP_PRE   = 2 * PWM_COUNTS / 256;
    localparam int     STEP_ODD   = 2 * STEP_DEN / 256;
    localparam int     STEP_BIAS  = STEP_DEN / 256;
    localparam int     STEP_SHIFT = 39;
    localparam longint STEP_RECIP = ((longint'(1) << STEP_SHIFT) + STEP_ODD - 1) / STEP_ODD;

    localparam logic [19:0] RST_COND_HIGH = 20'd32000;
    localparam logic [19:0] RST_COND_LOW  = 20'd0;
    localparam logic [6:0]  RST_GAIN      = 7'd10;
    localparam logic [13:0] RST_FINE      = 14'd20;
    localparam logic [13:0] RST_COARSE    = 14'd500;

    typedef enum logic [2:0] {
        REG_CH0_HIGH = 3'd0,
        REG_CH0_LOW  = 3'd1,
        REG_CH1_HIGH = 3'd2,
        REG_CH1_LOW  = 3'd3,
        REG_CH0_GAIN = 3'd4,
        REG_CH1_GAIN = 3'd5,
        REG_FINE     = 3'd6,
        REG_COARSE   = 3'd7
    } reg_idx_t;

    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_MAP  = 9'b0_0000_0010,
        S_DSET = 9'b0_0000_0100,
        S_DIV  = 9'b0_0000_1000,
        S_TGT  = 9'b0_0001_0000,
        S_BAND = 9'b0_0010_0000,
        S_STEP = 9'b0_0100_0000,
        S_UPD  = 9'b0_1000_0000,
        S_DONE = 9'b1_0000_0000
    } state_t;

endpackage

[sv/current_loop_duty_regulator.sv]
// top level of the two-channel 4-20 mA loop duty regulator
//
// input channel: in_valid/in_stall carry one sample beat (channel, fresh_sample,
// conductivity, loop_current_ua). output channel: out_valid/out_stall carry one
// beat (out_channel, duty_count) for every input beat, in order.
// a fresh sample runs through a sequencer around one restoring divider for the
// conductivity-to-current mapping; outside the bands the proportional step comes
// from a reciprocal multiply. equal range bounds skip the divider pass, and a
// stale sample goes straight to write-back. in_stall is high while a sample is in
// work, so the next sample can be taken in the cycle after the result is written;
// a new sample is never taken before the last one is through.
// the result sits in an output register; the next sample is taken while it
// waits, and only the final write-back waits for out_stall to drop.
// registers sit on an APB-style port at byte address 4*index, pready always high;
// write them only while the block is idle.
// reset (rst_n low, async) restores register defaults and zero duty on both
// channels.
`include "current_loop_duty_regulator_assert.svh"

module current_loop_duty_regulator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        channel,
    input  logic        fresh_sample,
    input  logic [19:0] conductivity,
    input  logic [14:0] loop_current_ua,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        out_channel,
    output logic [9:0]  duty_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [19:0] cond_high_reg [2];
    logic [19:0] cond_low_reg  [2];
    logic [6:0]  gain_reg      [2];
    logic [13:0] fine_reg;
    logic [13:0] coarse_reg;
    logic [9:0]  duty_store_reg [2];

    cldr_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // sample and work registers
    logic        ch_reg;
    logic        fresh_reg;
    logic [19:0] cond_reg;
    logic [14:0] cur_reg;
    logic [9:0]  duty_reg, duty_next;
    logic        eq_reg, eq_next;
    logic        neg_reg, neg_next;
    logic [34:0] n_reg, n_next;
    logic [20:0] d_reg, d_next;
    logic [cldr_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [cldr_pkg::DIV_W-1:0] dsh_reg, dsh_next;
    logic [14:0] quo_reg, quo_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic signed [16:0] err_reg, err_next;
    logic        out_channel_reg;
    logic [9:0]  duty_count_reg;

    logic in_take;
    logic out_free;
    logic cfg_write;
    cldr_pkg::reg_idx_t cfg_idx;

    logic [19:0] hi;
    logic [19:0] lo;
    logic [19:0] diff_hc;
    logic [19:0] diff_hl;
    logic [cldr_pkg::DIV_W-1:0] den2;
    logic        ge;
    logic [14:0] target;
    logic [15:0] aerr;
    logic        err_up;
    logic [21:0] step_x;
    logic [50:0] step_prod;
    logic [11:0] q12;
    logic [12:0] sum_up;

    function automatic logic [9:0] step_one(input logic [9:0] d, input logic up);
        logic [9:0] r;
        r = d;
        if (up)
        begin
            if (d < 10'(cldr_pkg::DUTY_MAX))
                r = d + 10'd1;
        end
        else if (d != 10'd0)
        begin
            r = d - 10'd1;
        end
        return r;
    endfunction

    assign in_stall  = (state_reg != cldr_pkg::S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign duty_count  = duty_count_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = cldr_pkg::reg_idx_t'(paddr[4:2]);

    always_comb
    begin
        case (cfg_idx)
            cldr_pkg::REG_CH0_HIGH: prdata = {12'd0, cond_high_reg[0]};
            cldr_pkg::REG_CH0_LOW:  prdata = {12'd0, cond_low_reg[0]};
            cldr_pkg::REG_CH1_HIGH: prdata = {12'd0, cond_high_reg[1]};
            cldr_pkg::REG_CH1_LOW:  prdata = {12'd0, cond_low_reg[1]};
            cldr_pkg::REG_CH0_GAIN: prdata = {25'd0, gain_reg[0]};
            cldr_pkg::REG_CH1_GAIN: prdata = {25'd0, gain_reg[1]};
            cldr_pkg::REG_FINE:     prdata = {18'd0, fine_reg};
            cldr_pkg::REG_COARSE:   prdata = {18'd0, coarse_reg};
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cond_high_reg[0] <= cldr_pkg::RST_COND_HIGH;
            cond_high_reg[1] <= cldr_pkg::RST_COND_HIGH;
            cond_low_reg[0]  <= cldr_pkg::RST_COND_LOW;
            cond_low_reg[1]  <= cldr_pkg::RST_COND_LOW;
            gain_reg[0]      <= cldr_pkg::RST_GAIN;
            gain_reg[1]      <= cldr_pkg::RST_GAIN;
            fine_reg         <= cldr_pkg::RST_FINE;
            coarse_reg       <= cldr_pkg::RST_COARSE;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                cldr_pkg::REG_CH0_HIGH: cond_high_reg[0] <= pwdata[19:0];
                cldr_pkg::REG_CH0_LOW:  cond_low_reg[0]  <= pwdata[19:0];
                cldr_pkg::REG_CH1_HIGH: cond_high_reg[1] <= pwdata[19:0];
                cldr_pkg::REG_CH1_LOW:  cond_low_reg[1]  <= pwdata[19:0];
                cldr_pkg::REG_CH0_GAIN: gain_reg[0]      <= pwdata[6:0];
                cldr_pkg::REG_CH1_GAIN: gain_reg[1]      <= pwdata[6:0];
                cldr_pkg::REG_FINE:     fine_reg         <= pwdata[13:0];
                cldr_pkg::REG_COARSE:   coarse_reg       <= pwdata[13:0];
                default:                ;
            endcase
        end
    end

    // datapath pieces shared by the states
    assign hi      = cond_high_reg[ch_reg];
    assign lo      = cond_low_reg[ch_reg];
    assign diff_hc = (hi >= cond_reg) ? (hi - cond_reg) : (cond_reg - hi);
    assign diff_hl = (hi >= lo) ? (hi - lo) : (lo - hi);
    assign den2    = {{(cldr_pkg::DIV_W - 22){1'b0}}, d_reg, 1'b0};
    assign ge      = (rem_reg >= dsh_reg);
    assign aerr    = err_reg[16] ? 16'(-err_reg) : err_reg[15:0];
    assign err_up  = !err_reg[16];
    assign step_x  = {7'd0, aerr[14:0]} * {15'd0, gain_reg[ch_reg]};
    assign step_prod = {26'd0, n_reg[24:0]} * 51'(cldr_pkg::STEP_RECIP);
    assign q12     = quo_reg[11:0];
    assign sum_up  = {3'd0, duty_reg} + {1'b0, q12};

    always_comb
    begin
        if (eq_reg)
            target = (cond_reg >= hi) ? 15'(cldr_pkg::CURRENT_MAX_UA)
                                      : 15'(cldr_pkg::CURRENT_MIN_UA);
        else if (neg_reg)
            target = 15'(cldr_pkg::CURRENT_MAX_UA);
        else if (quo_reg >= 15'(cldr_pkg::SPAN_UA))
            target = 15'(cldr_pkg::CURRENT_MIN_UA);
        else
            target = 15'(cldr_pkg::CURRENT_MAX_UA) - quo_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        duty_next      = duty_reg;
        eq_next        = eq_reg;
        neg_next       = neg_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            cldr_pkg::S_IDLE:
            begin
                if (in_take)
                begin
                    duty_next  = duty_store_reg[channel];
                    state_next = fresh_sample ? cldr_pkg::S_MAP : cldr_pkg::S_DONE;
                end
            end
            cldr_pkg::S_MAP:
            begin
                eq_next    = (hi == lo);
                neg_next   = (hi < cond_reg) != (hi < lo);
                n_next     = {15'd0, diff_hc} * 35'(cldr_pkg::SPAN_UA);
                d_next     = {1'b0, diff_hl};
                state_next = (hi == lo) ? cldr_pkg::S_TGT : cldr_pkg::S_DSET;
            end
            cldr_pkg::S_DSET:
            begin
                // rounded quotient: (2n + d) / 2d
                rem_next   = {1'b0, n_reg, 1'b0} + cldr_pkg::DIV_W'(d_reg);
                quo_next   = 15'd0;
                dsh_next   = den2 << cldr_pkg::MAP_TOP;
                cnt_next   = 4'(cldr_pkg::MAP_TOP);
                state_next = cldr_pkg::S_DIV;
            end
            cldr_pkg::S_DIV:
            begin
                if (ge)
                    rem_next = rem_reg - dsh_reg;
                quo_next = {quo_reg[13:0], ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                    state_next = cldr_pkg::S_TGT;
            end
            cldr_pkg::S_TGT:
            begin
                err_next   = $signed({2'b00, target}) - $signed({2'b00, cur_reg});
                state_next = cldr_pkg::S_BAND;
            end
            cldr_pkg::S_BAND:
            begin
                if (aerr <= {2'b00, fine_reg})
                begin
                    state_next = cldr_pkg::S_DONE;
                end
                else if (aerr < {2'b00, coarse_reg})
                begin
                    duty_next  = step_one(duty_reg, err_up);
                    state_next = cldr_pkg::S_DONE;
                end
                else
                begin
                    n_next     = {13'd0, step_x} * 35'(cldr_pkg::STEP_PRE)
                                 + 35'(cldr_pkg::STEP_BIAS);
                    state_next = cldr_pkg::S_STEP;
                end
            end
            cldr_pkg::S_STEP:
            begin
                quo_next   = {3'd0, step_prod[cldr_pkg::STEP_SHIFT +: 12]};
                state_next = cldr_pkg::S_UPD;
            end
            cldr_pkg::S_UPD:
            begin
                if (q12 == 12'd0)
                    duty_next = step_one(duty_reg, err_up);
                else if (err_up)
                    duty_next = (sum_up < 13'(cldr_pkg::DUTY_MAX)) ? sum_up[9:0]
                                                                    : step_one(duty_reg, 1'b1);
                else
                    duty_next = ({2'b00, duty_reg} > q12) ? (duty_reg - q12[9:0])
                                                          : step_one(duty_reg, 1'b0);
                state_next = cldr_pkg::S_DONE;
            end
            cldr_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = cldr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cldr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= cldr_pkg::S_IDLE;
            out_valid_reg     <= 1'b0;
            duty_store_reg[0] <= 10'd0;
            duty_store_reg[1] <= 10'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == cldr_pkg::S_DONE && out_free)
                duty_store_reg[ch_reg] <= duty_reg;
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ch_reg    <= channel;
            fresh_reg <= fresh_sample;
            cond_reg  <= conductivity;
            cur_reg   <= loop_current_ua;
        end
        if (state_reg == cldr_pkg::S_DONE && out_free)
        begin
            out_channel_reg <= ch_reg;
            duty_count_reg  <= duty_reg;
        end
        duty_reg  <= duty_next;
        eq_reg    <= eq_next;
        neg_reg   <= neg_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        err_reg   <= err_next;
    end

    // stale sample goes straight to write-back
    `CLDR_ASSERT(a_stale_skip,
        (in_take && !fresh_sample) |=> (state_reg == cldr_pkg::S_DONE && !fresh_reg))
    // divider pass ends in the state that uses its quotient
    `CLDR_ASSERT(a_div_exit,
        (state_reg == cldr_pkg::S_DIV && cnt_reg == 4'd0) |=>
        (state_reg == cldr_pkg::S_TGT))
    // proportional step always fits below the top quotient bit
    `CLDR_ASSERT(a_step_range, (state_reg == cldr_pkg::S_UPD) |-> !quo_reg[11])
    // fine band leaves the duty alone
    `CLDR_ASSERT(a_fine_hold,
        (state_reg == cldr_pkg::S_BAND && aerr <= {2'b00, fine_reg}) |=>
        (state_reg == cldr_pkg::S_DONE && $stable(duty_reg)))
    // reported duty matches the stored duty of that channel
    `CLDR_ASSERT(a_report_store,
        (state_reg == cldr_pkg::S_DONE && out_free) |=>
        (out_valid_reg && duty_count_reg == duty_store_reg[out_channel_reg]))
    `CLDR_ASSERT_ALWAYS(a_state_onehot, !rst_n || $onehot(state_reg))

endmodule

[test/current_loop_duty_regulator_test.sv]
// self-checking testbench for the two-channel loop duty regulator
`timescale 1ns / 100ps

module current_loop_duty_regulator_test;
    import cldr_pkg::*;

    typedef struct packed {
        logic        ch;
        logic        fresh;
        logic [19:0] cond;
        logic [14:0] cur;
    } sample_t;

    typedef struct packed {
        logic       ch;
        logic [9:0] duty;
    } duty_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        channel = 1'b0;
    logic        fresh_sample = 1'b0;
    logic [19:0] conductivity = '0;
    logic [14:0] loop_current_ua = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        out_channel;
    logic [9:0]  duty_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    current_loop_duty_regulator dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .channel         (channel),
        .fresh_sample    (fresh_sample),
        .conductivity    (conductivity),
        .loop_current_ua (loop_current_ua),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_channel     (out_channel),
        .duty_count      (duty_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // register copy and duty state of the predictor
    logic [19:0] span_high [2] = '{RST_COND_HIGH, RST_COND_HIGH};
    logic [19:0] span_low  [2] = '{RST_COND_LOW, RST_COND_LOW};
    logic [6:0]  loop_gain [2] = '{RST_GAIN, RST_GAIN};
    logic [13:0] fine_ua   = RST_FINE;
    logic [13:0] coarse_ua = RST_COARSE;
    int          duty_shadow [2] = '{0, 0};

    sample_t     sample_queue [$];
    duty_beat_t  duty_expected [$];
    int unsigned setting [8];

    bit in_beat_done = 1'b0;
    bit steady_flow  = 1'b0;
    int err_count    = 0;
    int checked_cnt  = 0;
    int sample_cnt   = 0;
    int stale_cnt    = 0;
    int hold_cnt     = 0;
    int nudge_cnt    = 0;
    int prop_cnt     = 0;
    int settings_cnt = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // nearest integer, ties away from zero
    function automatic longint div_nearest(input longint num, input longint den);
        bit     neg;
        longint n;
        longint d;
        longint q;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        q = (2 * n + d) / (2 * d);
        return neg ? -q : q;
    endfunction

    function automatic int nudge(input int d, input bit up);
        if (up)
            return (d < DUTY_MAX) ? d + 1 : d;
        return (d > 0) ? d - 1 : d;
    endfunction

    function automatic longint loop_target(input logic ch, input logic [19:0] cond);
        longint hi;
        longint lo;
        longint tgt;
        hi = longint'(span_high[ch]);
        lo = longint'(span_low[ch]);
        if (hi == lo)
            tgt = (longint'(cond) >= hi) ? CURRENT_MAX_UA : CURRENT_MIN_UA;
        else
            tgt = CURRENT_MAX_UA - div_nearest((hi - longint'(cond)) * SPAN_UA, hi - lo);
        if (tgt < CURRENT_MIN_UA)
            tgt = CURRENT_MIN_UA;
        else if (tgt > CURRENT_MAX_UA)
            tgt = CURRENT_MAX_UA;
        return tgt;
    endfunction

    function automatic logic [9:0] regulated_duty(input sample_t s);
        longint err;
        longint aerr;
        longint stp;
        longint nxt;
        int     d;
        d = duty_shadow[s.ch];
        if (s.fresh)
        begin
            err = loop_target(s.ch, s.cond) - longint'(s.cur);
            aerr = (err < 0) ? -err : err;
            if (aerr <= longint'(fine_ua))
                hold_cnt++;
            else if (aerr < longint'(coarse_ua))
            begin
                d = nudge(d, err > 0);
                nudge_cnt++;
            end
            else
            begin
                stp = div_nearest(err * PWM_COUNTS * longint'(loop_gain[s.ch]), STEP_DEN);
                nxt = longint'(d) + stp;
                prop_cnt++;
                if (stp == 0)
                    d = nudge(d, err > 0);
                else if (stp > 0)
                    d = (nxt < DUTY_MAX) ? int'(nxt) : nudge(d, 1'b1);
                else
                    d = (nxt > 0) ? int'(nxt) : nudge(d, 1'b0);
            end
            duty_shadow[s.ch] = d;
        end
        return d[9:0];
    endfunction

    // input driver: holds a beat until taken, idles now and then
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_beat_done))
        begin
            in_beat_done = 1'b0;
            if (sample_queue.size() != 0 && (steady_flow || $urandom_range(99) >= 9))
            begin
                in_valid        <= 1'b1;
                channel         <= sample_queue[0].ch;
                fresh_sample    <= sample_queue[0].fresh;
                conductivity    <= sample_queue[0].cond;
                loop_current_ua <= sample_queue[0].cur;
                void'(sample_queue.pop_front());
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_stall <= !steady_flow && ($urandom_range(99) < 9);
    end

    // monitor: result check first, then prediction of the beat taken at this edge
    always @(posedge clk)
    begin
        duty_beat_t got;
        duty_beat_t want;
        sample_t    s;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{out_channel, duty_count};
                if (duty_expected.size() == 0)
                begin
                    $error("duty beat on channel %0d with no sample outstanding", got.ch);
                    err_count++;
                end
                else
                begin
                    want = duty_expected.pop_front();
                    checked_cnt++;
                    if (got.ch !== want.ch)
                    begin
                        $error("out_channel: expected %0d, got %0d", want.ch, got.ch);
                        err_count++;
                    end
                    if (got.duty !== want.duty)
                    begin
                        $error("duty_count: expected %0d, got %0d", want.duty, got.duty);
                        err_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                s = '{channel, fresh_sample, conductivity, loop_current_ua};
                sample_cnt++;
                if (!s.fresh)
                    stale_cnt++;
                duty_expected.push_back('{s.ch, regulated_duty(s)});
                in_beat_done = 1'b1;
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CH0_HIGH: span_high[0] = val[19:0];
            REG_CH0_LOW:  span_low[0]  = val[19:0];
            REG_CH1_HIGH: span_high[1] = val[19:0];
            REG_CH1_LOW:  span_low[1]  = val[19:0];
            REG_CH0_GAIN: loop_gain[0] = val[6:0];
            REG_CH1_GAIN: loop_gain[1] = val[6:0];
            REG_FINE:     fine_ua      = val[13:0];
            REG_COARSE:   coarse_ua    = val[13:0];
            default: ;
        endcase
    endtask

    // sender pauses until every queued beat is taken and every result is back
    task automatic drain();
        while (sample_queue.size() != 0 || duty_expected.size() != 0 || in_valid)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_setting();
        drain();
        for (int i = 0; i < 8; i++)
            write_reg(reg_idx_t'(i), setting[i]);
        settings_cnt++;
    endtask

    task automatic queue_sample(input logic ch, input logic fresh, input logic [19:0] cond,
                                input int cur);
        sample_queue.push_back('{ch, fresh, cond, cur[14:0]});
    endtask

    // mostly fresh samples whose current lands near the target to reach the bands
    task automatic run_random(input int count);
        sample_t s;
        int      pick;
        int      lo;
        int      hi;
        int      v;
        int      w;
        for (int n = 0; n < count; n++)
        begin
            s.ch    = $urandom_range(1, 0);
            s.fresh = ($urandom_range(99) < 88);
            lo = (span_low[s.ch] < span_high[s.ch]) ? span_low[s.ch] : span_high[s.ch];
            hi = (span_low[s.ch] < span_high[s.ch]) ? span_high[s.ch] : span_low[s.ch];
            pick = $urandom_range(9);
            if (pick < 5)
                v = lo + int'($urandom_range(hi - lo));
            else if (pick < 7)
                v = $urandom & 20'hFFFFF;
            else
                v = ((pick == 7) ? int'(span_high[s.ch]) : int'(span_low[s.ch]))
                    + int'($urandom_range(8)) - 4;
            if (v < 0)
                v = 0;
            if (v > 20'hFFFFF)
                v = 20'hFFFFF;
            s.cond = v[19:0];
            if ($urandom_range(9) < 4)
                v = $urandom_range(25000);
            else
            begin
                case ($urandom_range(2))
                    0:       w = fine_ua + 5;
                    1:       w = coarse_ua + 50;
                    default: w = 600;
                endcase
                v = int'(loop_target(s.ch, s.cond)) + int'($urandom_range(2 * w)) - w;
                if (v < 0)
                    v = 0;
                if (v > 25000)
                    v = 25000;
            end
            s.cur = v[14:0];
            sample_queue.push_back(s);
        end
        drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: stale, field extremes, both bands, bottom limit
        queue_sample(1'b0, 1'b0, 20'hFFFFF, 0);
        queue_sample(1'b0, 1'b1, 20'd32000, 4000);
        queue_sample(1'b1, 1'b1, 20'd0, 25000);
        queue_sample(1'b0, 1'b1, 20'd32000, 19980);
        queue_sample(1'b0, 1'b1, 20'd32000, 19600);
        queue_sample(1'b0, 1'b1, 20'd32000, 20400);
        queue_sample(1'b1, 1'b1, 20'hFFFFF, 16000);
        queue_sample(1'b1, 1'b0, 20'h5A5A5, 21845);
        drain();

        // high gain, empty bands: top limit, zero step, drop to bottom
        setting = '{32000, 0, 32000, 0, 127, 127, 0, 0};
        program_setting();
        for (int i = 0; i < 14; i++)
            queue_sample(1'b0, 1'b1, 20'd32000, 0);
        queue_sample(1'b0, 1'b1, 20'd32000, 19999);
        queue_sample(1'b0, 1'b1, 20'd0, 25000);
        queue_sample(1'b1, 1'b1, 20'd16000, 12000);
        drain();

        // equal bounds, reversed range, zero gain
        setting = '{1000, 1000, 0, 20'hFFFFF, 0, 100, 0, 16000};
        program_setting();
        queue_sample(1'b0, 1'b1, 20'd999, 0);
        queue_sample(1'b0, 1'b1, 20'd1000, 0);
        queue_sample(1'b1, 1'b1, 20'd0, 25000);
        queue_sample(1'b1, 1'b1, 20'hFFFFF, 0);
        queue_sample(1'b1, 1'b1, 20'h80000, 12000);
        drain();

        setting = '{32000, 0, 32000, 0, 10, 10, 20, 500};
        program_setting();
        run_random(220);

        setting = '{20'hFFFFF, 0, 20'hFFFFF, 20'h7FFFF, 100, 50, 0, 16000};
        program_setting();
        run_random(220);

        // no idling on either side through this setting
        setting = '{5000, 5000, 1000, 60000, 127, 0, 100, 100};
        program_setting();
        steady_flow = 1'b1;
        run_random(220);
        steady_flow = 1'b0;

        setting = '{800000, 12345, 3000, 2000, 1, 100, 16000, 0};
        program_setting();
        run_random(220);

        setting = '{0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 64, 127, 300, 2000};
        program_setting();
        run_random(220);

        for (int p = 0; p < 2; p++)
        begin
            setting = '{$urandom & 20'hFFFFF, $urandom & 20'hFFFFF,
                        $urandom & 20'hFFFFF, $urandom & 20'hFFFFF,
                        $urandom_range(127), $urandom_range(127),
                        $urandom_range(800), $urandom_range(3000)};
            program_setting();
            run_random(225);
        end

        repeat (50) @(posedge clk);
        if (duty_expected.size() != 0)
        begin
            $error("%0d duty beats never arrived", duty_expected.size());
            err_count++;
        end
        $display("checked %0d duty beats from %0d samples (%0d stale) under %0d settings",
                 checked_cnt, sample_cnt, stale_cnt, settings_cnt);
        $display("fresh steps: %0d held, %0d single-count, %0d proportional",
                 hold_cnt, nudge_cnt, prop_cnt);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/cldr_pkg.sv
sv/current_loop_duty_regulator.sv
test/current_loop_duty_regulator_test.sv
